FILE: src/sic_pkg.sv
// shared types and constants for the interleaving string check
// no dependencies
package sic_pkg;

   localparam int MAX_PART   = 32;
   localparam int MAX_TARGET = 64;

   localparam int PART_W = $clog2(MAX_PART + 1);
   localparam int TGT_W  = $clog2(MAX_TARGET + 1);
   localparam int PIDX_W = (MAX_PART > 1) ? $clog2(MAX_PART) : 1;
   localparam int TIDX_W = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
   localparam int ROW_W  = $clog2(MAX_PART + 1);

   localparam logic [1:0] OP_FIRST  = 2'd0;
   localparam logic [1:0] OP_SECOND = 2'd1;
   localparam logic [1:0] OP_TARGET = 2'd2;
   localparam logic [1:0] OP_EVAL   = 2'd3;

   localparam logic [1:0] ST_VALID    = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       has_mark;
      logic       source;
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       fill_init;
      logic       fill_calc;
      logic       walk_init;
      logic       walk_emit;
      logic       stat_emit;
      logic [1:0] stat_code;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic overflow;
      logic len_ok;
      logic i_zero;
      logic j_zero;
      logic origin_ok;
      logic target_empty;
      logic walk_last;
      logic out_free;
   } stat_type;

endpackage

FILE: src/sic_ctrl.sv
// controller state machine for the interleaving string check
// depends on sic_pkg
module sic_ctrl
   import sic_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  req_type  req_data,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE, FILL_RD, FILL_CALC, CHECK, WALK_RD, WALK_EMIT, STATUS
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       accept;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               if (req_data.operation != OP_EVAL) begin
                  cmd.load = 1'b1;
               end else if (stat.overflow) begin
                  code_in  = ST_OVERFLOW;
                  state_in = STATUS;
               end else if (!stat.len_ok) begin
                  code_in  = ST_INVALID;
                  state_in = STATUS;
               end else begin
                  cmd.fill_init = 1'b1;
                  state_in      = FILL_RD;
               end
            end
         end
         FILL_RD: state_in = FILL_CALC;
         FILL_CALC: begin
            cmd.fill_calc = 1'b1;
            state_in = (stat.i_zero && stat.j_zero) ? CHECK : FILL_RD;
         end
         CHECK: begin
            if (!stat.origin_ok) begin
               code_in  = ST_INVALID;
               state_in = STATUS;
            end else if (stat.target_empty) begin
               code_in  = ST_VALID;
               state_in = STATUS;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = WALK_RD;
            end
         end
         WALK_RD: state_in = WALK_EMIT;
         WALK_EMIT: begin
            if (stat.out_free) begin
               cmd.walk_emit = 1'b1;
               if (stat.walk_last) begin
                  cmd.clear = 1'b1;
                  state_in  = IDLE;
               end else begin
                  state_in = WALK_RD;
               end
            end
         end
         STATUS: begin
            if (stat.out_free) begin
               cmd.stat_emit = 1'b1;
               cmd.clear     = 1'b1;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      cmd.stat_code = code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         code_ff  <= ST_VALID;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

FILE: src/sic_dp.sv
// datapath: string stores, reach table, fill and walk logic, result register
// depends on sic_pkg
module sic_dp
   import sic_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  logic     rsp_stall
);

   logic [7:0]        first_mem  [MAX_PART];
   logic [7:0]        second_mem [MAX_PART];
   logic [7:0]        target_mem [MAX_TARGET];
   logic [MAX_PART:0] reach_mem  [MAX_PART + 1];

   logic [PART_W-1:0] n1_ff, n2_ff;
   logic [TGT_W-1:0]  nt_ff;
   logic              ovf_ff;
   logic [PART_W-1:0] i_ff, j_ff;
   logic [MAX_PART:0] cur_ff, prev_ff;
   logic [7:0]        f_rd_ff, s_rd_ff, t_rd_ff;
   logic [MAX_PART:0] row_rd_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [TGT_W:0]    sum_ij;
   logic [ROW_W-1:0]  row_addr;
   logic              ok, take;
   logic [MAX_PART:0] cur_nx;
   logic              wr_first, wr_second, wr_target;

   assign sum_ij = {{(TGT_W + 1 - PART_W){1'b0}}, i_ff}
                 + {{(TGT_W + 1 - PART_W){1'b0}}, j_ff};
   // row below the current one, clamped so the address stays in range
   assign row_addr = (i_ff >= PART_W'(MAX_PART)) ? ROW_W'(MAX_PART)
                                                 : ROW_W'(i_ff + 1'b1);

   // reads run every cycle; data is valid the cycle after addresses settle
   always_ff @(posedge clock) begin
      f_rd_ff   <= first_mem[i_ff[PIDX_W-1:0]];
      s_rd_ff   <= second_mem[j_ff[PIDX_W-1:0]];
      t_rd_ff   <= target_mem[sum_ij[TIDX_W-1:0]];
      row_rd_ff <= reach_mem[row_addr];
      if (wr_first)  first_mem[n1_ff[PIDX_W-1:0]]  <= req_data.char_in;
      if (wr_second) second_mem[n2_ff[PIDX_W-1:0]] <= req_data.char_in;
      if (wr_target) target_mem[nt_ff[TIDX_W-1:0]] <= req_data.char_in;
      if (cmd.fill_calc && j_ff == '0) reach_mem[i_ff] <= cur_nx;
   end

   assign wr_first  = cmd.load && req_data.operation == OP_FIRST
                      && n1_ff < PART_W'(MAX_PART);
   assign wr_second = cmd.load && req_data.operation == OP_SECOND
                      && n2_ff < PART_W'(MAX_PART);
   assign wr_target = cmd.load && req_data.operation == OP_TARGET
                      && nt_ff < TGT_W'(MAX_TARGET);

   always_comb begin
      ok = (i_ff == n1_ff && j_ff == n2_ff)
         || (i_ff < n1_ff && f_rd_ff == t_rd_ff && prev_ff[j_ff])
         || (j_ff < n2_ff && s_rd_ff == t_rd_ff && j_ff < PART_W'(MAX_PART)
             && cur_ff[ROW_W'(j_ff + 1'b1)]);
      cur_nx = cur_ff | ((MAX_PART + 1)'(ok) << j_ff);
      take   = i_ff < n1_ff && f_rd_ff == t_rd_ff && row_rd_ff[j_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_init) begin
         i_ff    <= n1_ff;
         j_ff    <= n2_ff;
         cur_ff  <= '0;
         prev_ff <= '0;
      end else if (cmd.fill_calc) begin
         if (j_ff == '0) begin
            prev_ff <= cur_nx;
            cur_ff  <= '0;
            i_ff    <= i_ff - 1'b1;
            j_ff    <= n2_ff;
         end else begin
            cur_ff <= cur_nx;
            j_ff   <= j_ff - 1'b1;
         end
      end else if (cmd.walk_init) begin
         i_ff <= '0;
         j_ff <= '0;
      end else if (cmd.walk_emit) begin
         if (take) i_ff <= i_ff + 1'b1;
         else      j_ff <= j_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         n1_ff  <= '0;
         n2_ff  <= '0;
         nt_ff  <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.load) begin
         if (wr_first)       n1_ff  <= n1_ff + 1'b1;
         else if (wr_second) n2_ff  <= n2_ff + 1'b1;
         else if (wr_target) nt_ff  <= nt_ff + 1'b1;
         else                ovf_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.walk_emit || cmd.stat_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.walk_emit) begin
         rsp_ff.status   <= ST_VALID;
         rsp_ff.has_mark <= 1'b1;
         rsp_ff.source   <= !take;
         rsp_ff.char_out <= t_rd_ff;
         rsp_ff.last     <= stat.walk_last;
      end else if (cmd.stat_emit) begin
         rsp_ff.status   <= cmd.stat_code;
         rsp_ff.has_mark <= 1'b0;
         rsp_ff.source   <= 1'b0;
         rsp_ff.char_out <= 8'd0;
         rsp_ff.last     <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      stat.overflow     = ovf_ff;
      stat.len_ok       = ({{(TGT_W + 1 - PART_W){1'b0}}, n1_ff}
                         + {{(TGT_W + 1 - PART_W){1'b0}}, n2_ff})
                         == {1'b0, nt_ff};
      stat.i_zero       = (i_ff == '0);
      stat.j_zero       = (j_ff == '0);
      stat.origin_ok    = prev_ff[0];
      stat.target_empty = (nt_ff == '0);
      stat.walk_last    = (sum_ij + 1'b1) == {1'b0, nt_ff};
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

endmodule

FILE: src/string_interleave_check.sv
// top level of the interleaving string check: controller plus datapath
// sequence: a load is written directly from idle; evaluate fills (n1+1)*(n2+1) table cells
// through FILL_RD and FILL_CALC, then walks the target through WALK_RD and WALK_EMIT per byte
// throughput: one load per cycle; no new transaction is taken while an evaluate runs
// reset: synchronous active high; clears counts, overflow flag, state and result valid
// depends on sic_pkg, sic_ctrl, sic_dp
module string_interleave_check
   import sic_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   // command and status between controller and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: loads, table fill, walk and status emission
   sic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stores, reach table and the result register
   sic_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

FILE: tb/sv/tb_string_interleave_check.sv
// testbench for string_interleave_check: loads random byte strings, evaluates them,
// and checks every result against an in-bench prediction of the interleave decision
// depends on sic_pkg and string_interleave_check
module tb_string_interleave_check
   import sic_pkg::*;
();

   // keeps the predicted stores and the queue of results still owed by the block
   class interleave_scoreboard;
      logic [7:0] first_bytes[$];
      logic [7:0] second_bytes[$];
      logic [7:0] target_bytes[$];
      bit         overflowed;
      rsp_type    owed[$];
      int         errors;
      int         evals;
      int         marks;

      // table cell (i,j): rest of target reachable with i of first, j of second used
      function void predict_eval();
         bit      reach[MAX_PART+2][MAX_PART+2];
         int      n1;
         int      n2;
         int      p;
         int      i;
         int      j;
         rsp_type r;
         n1 = first_bytes.size();
         n2 = second_bytes.size();
         evals++;
         r = '0;
         r.last = 1'b1;
         if (overflowed) begin
            r.status = ST_OVERFLOW;
            owed.push_back(r);
         end else if (n1 + n2 != target_bytes.size()) begin
            r.status = ST_INVALID;
            owed.push_back(r);
         end else begin
            foreach (reach[a, b]) reach[a][b] = 0;
            for (i = n1; i >= 0; i--) begin
               for (j = n2; j >= 0; j--) begin
                  p = i + j;
                  if (i == n1 && j == n2) reach[i][j] = 1;
                  else if ((i < n1 && first_bytes[i] == target_bytes[p] && reach[i+1][j]) ||
                           (j < n2 && second_bytes[j] == target_bytes[p] && reach[i][j+1]))
                     reach[i][j] = 1;
               end
            end
            if (!reach[0][0]) begin
               r.status = ST_INVALID;
               owed.push_back(r);
            end else if (n1 + n2 == 0) begin
               r.status = ST_VALID;
               owed.push_back(r);
            end else begin
               // walk prefers the first string whenever that still completes
               i = 0;
               j = 0;
               for (p = 0; p < n1 + n2; p++) begin
                  r = '0;
                  r.status   = ST_VALID;
                  r.has_mark = 1'b1;
                  r.char_out = target_bytes[p];
                  if (i < n1 && first_bytes[i] == target_bytes[p] && reach[i+1][j]) begin
                     r.source = 1'b0;
                     i++;
                  end else begin
                     r.source = 1'b1;
                     j++;
                  end
                  r.last = (p + 1 == n1 + n2);
                  owed.push_back(r);
                  marks++;
               end
            end
         end
         first_bytes.delete();
         second_bytes.delete();
         target_bytes.delete();
         overflowed = 0;
      endfunction

      function void note_request(req_type t);
         case (t.operation)
            OP_FIRST: begin
               if (first_bytes.size() < MAX_PART) first_bytes.push_back(t.char_in);
               else overflowed = 1;
            end
            OP_SECOND: begin
               if (second_bytes.size() < MAX_PART) second_bytes.push_back(t.char_in);
               else overflowed = 1;
            end
            OP_TARGET: begin
               if (target_bytes.size() < MAX_TARGET) target_bytes.push_back(t.char_in);
               else overflowed = 1;
            end
            default: predict_eval();
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.has_mark !== want.has_mark) begin
            $error("has_mark expected %0d actual %0d", want.has_mark, got.has_mark);
            errors++;
         end
         if (got.source !== want.source) begin
            $error("source expected %0d actual %0d", want.source, got.source);
            errors++;
         end
         if (got.char_out !== want.char_out) begin
            $error("char_out expected %0h actual %0h", want.char_out, got.char_out);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 0;

   interleave_scoreboard sb = new();
   bit  quiet_tail = 0;   // no idling in the last part of the run
   bit  long_hold  = 0;   // request for a long receiver hold-off
   int  idle_cycles = 0;
   int  sent = 0;

   string_interleave_check dut (.*);

   always #5 clock = ~clock;

   // results are checked at the edge where they are accepted
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (!reset && (req_valid && !req_stall || rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("string_interleave_check test failed");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            rsp_stall <= 0;
            long_hold = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   // one transaction to the block, with an optional idle burst before it
   task automatic send(logic [1:0] op, logic [7:0] ch);
      req_type t;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      t.operation = op;
      t.char_in   = ch;
      req_data  <= t;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(t);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // build a string pair and a target; mostly true interleavings with random content
   task automatic send_case(int n1, int n2, bit make_valid, bit flip);
      logic [7:0] a[$];
      logic [7:0] b[$];
      logic [7:0] t[$];
      int         i;
      int         j;
      logic [7:0] alphabet;
      alphabet = $urandom_range(0, 1) ? 8'd3 : 8'hff;   // small alphabet makes ties
      for (i = 0; i < n1; i++) a.push_back(8'($urandom) & alphabet);
      for (i = 0; i < n2; i++) b.push_back(8'($urandom) & alphabet);
      i = 0;
      j = 0;
      while (i < n1 || j < n2) begin
         if (j >= n2 || (i < n1 && $urandom_range(0, 1))) t.push_back(a[i++]);
         else t.push_back(b[j++]);
      end
      if (!make_valid) begin
         if (flip && t.size() > 0) t[$urandom_range(0, t.size()-1)] ^= 8'h01;
         else t.push_back(8'($urandom));
      end
      // loads arrive interleaved in random order
      while (a.size() + b.size() + t.size() > 0) begin
         case ($urandom_range(0, 2))
            0: if (a.size()) send(OP_FIRST, a.pop_front());
            1: if (b.size()) send(OP_SECOND, b.pop_front());
            default: if (t.size()) send(OP_TARGET, t.pop_front());
         endcase
      end
      send(OP_EVAL, 8'($urandom));
   endtask

   initial begin : stimulus
      int k;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty strings, extreme bytes, mismatch, overflow on the first and second stores
      send(OP_EVAL, 8'hff);
      send(OP_FIRST, 8'h00);
      send(OP_SECOND, 8'hff);
      send(OP_TARGET, 8'hff);
      send(OP_TARGET, 8'h00);
      send(OP_EVAL, 8'h00);
      send(OP_FIRST, 8'haa);
      send(OP_TARGET, 8'h55);
      send(OP_EVAL, 8'h00);
      send(OP_SECOND, 8'h12);
      send(OP_EVAL, 8'h00);
      send_case(1, 1, 1, 0);
      for (k = 0; k < MAX_PART + 1; k++) send(OP_FIRST, 8'($urandom));
      send(OP_EVAL, 8'h00);
      for (k = 0; k < MAX_PART + 1; k++) send(OP_SECOND, 8'($urandom));
      send(OP_EVAL, 8'h00);
      drain();

      // full sizes once: both parts and the target at capacity
      send_case(MAX_PART, MAX_PART, 1, 0);
      for (k = 0; k < MAX_TARGET + 1; k++) send(OP_TARGET, 8'($urandom));
      send(OP_EVAL, 8'h00);

      // sender pauses until every expected result has come
      drain();

      // long receiver hold-off while loads and evaluates keep coming
      long_hold = 1;
      for (k = 0; k < 4; k++) send_case($urandom_range(1, 3), $urandom_range(1, 3), 1, 0);

      // random part, mostly small sizes
      while (sent < 360) begin
         if (sent > 330) quiet_tail = 1;
         k = $urandom_range(0, 9);
         if (k < 6) send_case($urandom_range(0, 5), $urandom_range(0, 5), 1, 0);
         else if (k < 8) send_case($urandom_range(0, 5), $urandom_range(0, 5), 0, k[0]);
         else if (k == 8) send(2'($urandom_range(0, 3)), 8'($urandom));
         else send_case($urandom_range(0, 12), $urandom_range(0, 12), 1, 0);
      end
      send(OP_EVAL, 8'h00);
      drain();
      repeat (100) @(posedge clock);

      $display("covered %0d transactions, %0d evaluates, %0d source marks",
               sent, sb.evals, sb.marks);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("string_interleave_check test passed");
      end else begin
         $display("string_interleave_check test failed");
      end
      $finish;
   end
endmodule
